// ===== rtl/core/rsa_modular_exponentiation_defines.svh =====
// assertion macros for the rsa exponentiation engine
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RSA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rsa_pkg.sv =====
// shared types and constants of the rsa exponentiation engine
package rsa_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int MIN_OP_W = 12;

	localparam int PRIME_P = 61;
	localparam int PRIME_Q = 53;
	localparam int RESET_MODULUS = PRIME_P * PRIME_Q;
	localparam int RESET_PUB_EXP = 17;
	localparam int RESET_PRIV_EXP = 2753;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd2;

	localparam logic FUNC_ENCRYPT = 1'b0;
	localparam logic FUNC_DECRYPT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_MULT,
		ST_NEXT,
		ST_SQR
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul_step;
		logic setup_mul;
		logic setup_sqr;
		logic wr_base;
		logic wr_acc;
		logic shift_exp;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_last;
		logic exp_zero;
		logic exp_lsb;
		logic exp_rest_zero;
	} dp_status_t;

endpackage

// ===== rtl/core/rsa_modular_exponentiation.sv =====
// top level of the rsa exponentiation engine: key registers, sequencer and datapath
// operand width W = max(WORD_BITS, 12); the modular multiplier is bit-serial
// one item at a time, busy high throughout
// done strobes one cycle with result_value; the receiver cannot stall
// reset: asynchronous, active low, loads modulus 3233, exponents 17 and 2753, goes idle
module rsa_modular_exponentiation import rsa_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 func,
	input  logic [DATA_W-1:0]    data_value,
	output logic                 done,
	output logic [DATA_W-1:0]    result_value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	`include "rsa_modular_exponentiation_defines.svh"

	localparam int OP_BITS = (WORD_BITS > MIN_OP_W) ? WORD_BITS : MIN_OP_W;

	logic [OP_BITS-1:0] mod_q;
	logic [OP_BITS-1:0] pub_q;
	logic [OP_BITS-1:0] priv_q;
	logic [OP_BITS-1:0] cfg_word;
	logic               cfg_fire;
	logic               mod_low_write;
	logic [OP_BITS-1:0] result;
	dp_cmd_t            cmd;
	dp_status_t         status;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign cfg_word = OP_BITS'(cfg_data[WORD_BITS-1:0]);
	assign mod_low_write = cfg_fire && (cfg_index == REG_MODULUS) && (cfg_word < OP_BITS'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= OP_BITS'(RESET_MODULUS);
			pub_q <= OP_BITS'(RESET_PUB_EXP);
			priv_q <= OP_BITS'(RESET_PRIV_EXP);
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_MODULUS: begin
					if (cfg_word >= OP_BITS'(2)) begin
						mod_q <= cfg_word;
					end
				end
				REG_PUB_EXP: begin
					pub_q <= cfg_word;
				end
				REG_PRIV_EXP: begin
					priv_q <= cfg_word;
				end
				default: begin
				end
			endcase
		end
	end

	rsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	rsa_dp #(
		.WORD_BITS (WORD_BITS),
		.OP_BITS   (OP_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (func),
		.data_value (data_value),
		.modulus    (mod_q),
		.pub_exp    (pub_q),
		.priv_exp   (priv_q),
		.status     (status),
		.done       (done),
		.result     (result)
	);

	assign result_value = DATA_W'(result);

	`RSA_ASSERT_IMP(a_result_below_mod, done, result < mod_q, "result not reduced below modulus")
	`RSA_ASSERT_NXT(a_start_takes, start && !busy, busy, "accepted start did not raise busy")
	`RSA_ASSERT_NXT(a_done_single, done, !done, "done strobe longer than one cycle")
	`RSA_ASSERT_NXT(a_mod_guard, mod_low_write, $stable(mod_q), "modulus below two was taken")

endmodule

// ===== rtl/core/rsa_ctrl.sv =====
// sequencer for reduce, multiply and square steps
module rsa_ctrl import rsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.mul_step = 1'b1;
				if (status.mul_last) begin
					cmd.wr_base = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.exp_zero) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end else if (status.exp_lsb) begin
					cmd.setup_mul = 1'b1;
					state_d = ST_MULT;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_MULT: begin
				cmd.mul_step = 1'b1;
				if (status.mul_last) begin
					cmd.wr_acc = 1'b1;
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				cmd.shift_exp = 1'b1;
				if (status.exp_rest_zero) begin
					state_d = ST_CHECK;
				end else begin
					cmd.setup_sqr = 1'b1;
					state_d = ST_SQR;
				end
			end
			ST_SQR: begin
				cmd.mul_step = 1'b1;
				if (status.mul_last) begin
					cmd.wr_base = 1'b1;
					state_d = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/rsa_dp.sv =====
// operand registers and bit-serial modular multiplier
module rsa_dp import rsa_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int OP_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic               func,
	input  logic [DATA_W-1:0]  data_value,
	input  logic [OP_BITS-1:0] modulus,
	input  logic [OP_BITS-1:0] pub_exp,
	input  logic [OP_BITS-1:0] priv_exp,
	output dp_status_t         status,
	output logic               done,
	output logic [OP_BITS-1:0] result
);

	localparam int CNT_W = $clog2(OP_BITS);

	logic [OP_BITS-1:0] m_q;
	logic [OP_BITS-1:0] e_q;
	logic [OP_BITS-1:0] acc_q;
	logic [OP_BITS-1:0] base_q;
	logic [OP_BITS-1:0] a_q;
	logic [OP_BITS-1:0] b_q;
	logic [OP_BITS-1:0] r_q;
	logic [OP_BITS-1:0] result_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;

	logic [OP_BITS:0]   m_ext;
	logic [OP_BITS:0]   dbl;
	logic [OP_BITS:0]   dbl_sub;
	logic [OP_BITS-1:0] r_half;
	logic [OP_BITS:0]   sum;
	logic [OP_BITS:0]   sum_sub;
	logic [OP_BITS-1:0] r_next;

	// r = 2r + a_bit * b mod m, with r and b below m
	always_comb begin
		m_ext = {1'b0, m_q};
		dbl = {r_q, 1'b0};
		dbl_sub = dbl - m_ext;
		r_half = (dbl >= m_ext) ? dbl_sub[OP_BITS-1:0] : dbl[OP_BITS-1:0];
		sum = {1'b0, r_half} + (a_q[OP_BITS-1] ? {1'b0, b_q} : '0);
		sum_sub = sum - m_ext;
		r_next = (sum >= m_ext) ? sum_sub[OP_BITS-1:0] : sum[OP_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.capture || cmd.setup_mul || cmd.setup_sqr) begin
				cnt_q <= '0;
			end else if (cmd.mul_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			m_q <= modulus;
			e_q <= (func == FUNC_DECRYPT) ? priv_exp : pub_exp;
			acc_q <= OP_BITS'(1);
			a_q <= OP_BITS'(data_value[WORD_BITS-1:0]);
			b_q <= OP_BITS'(1);
			r_q <= '0;
		end else if (cmd.setup_mul) begin
			a_q <= acc_q;
			b_q <= base_q;
			r_q <= '0;
		end else if (cmd.setup_sqr) begin
			a_q <= base_q;
			b_q <= base_q;
			r_q <= '0;
		end else if (cmd.mul_step) begin
			a_q <= a_q << 1;
			r_q <= r_next;
		end
		if (cmd.wr_base) begin
			base_q <= r_next;
		end
		if (cmd.wr_acc) begin
			acc_q <= r_next;
		end
		if (cmd.shift_exp) begin
			e_q <= e_q >> 1;
		end
		if (cmd.emit) begin
			result_q <= acc_q;
		end
	end

	assign status.mul_last = (cnt_q == CNT_W'(OP_BITS - 1));
	assign status.exp_zero = (e_q == '0);
	assign status.exp_lsb = e_q[0];
	assign status.exp_rest_zero = (e_q[OP_BITS-1:1] == '0);

	assign done = done_q;
	assign result = result_q;

endmodule
